@@ rtl/dead_reckoning_servo_positioner_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the servo positioner RTL.
// ----------------------------------------------------------------------------
`ifndef DEAD_RECKONING_SERVO_POSITIONER_MACROS_SVH
`define DEAD_RECKONING_SERVO_POSITIONER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DRSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/drsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo positioner package
// Word types, register map and shared helpers.
// ----------------------------------------------------------------------------
package drsp_pkg;

    localparam int POS_W   = 24;
    localparam int SPEED_W = 16;
    localparam int PULSE_W = 12;
    localparam int TIME_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int PROD_W  = SPEED_W + TIME_W;
    localparam int STEP_W  = 26;
    localparam int SUM_W   = 27;

    localparam logic [PROD_W-1:0] STEP_LIMIT = PROD_W'(1) << 25;

    // Command word actions
    localparam logic ACT_MOVE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_MIN_POSITION   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_POSITION   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPEED_PER_MS   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DEADBAND       = 3'd3;
    localparam logic [IDX_W-1:0] REG_PULSE_STOP     = 3'd4;
    localparam logic [IDX_W-1:0] REG_PULSE_FORWARD  = 3'd5;
    localparam logic [IDX_W-1:0] REG_PULSE_BACKWARD = 3'd6;

    // Reset values
    localparam logic [POS_W-1:0]   RST_MIN_POSITION   = 24'd0;
    localparam logic [POS_W-1:0]   RST_MAX_POSITION   = 24'hFFFFFF;
    localparam logic [SPEED_W-1:0] RST_SPEED_PER_MS   = 16'd400;
    localparam logic [POS_W-1:0]   RST_DEADBAND       = 24'd3277;
    localparam logic [PULSE_W-1:0] RST_PULSE_STOP     = 12'd1500;
    localparam logic [PULSE_W-1:0] RST_PULSE_FORWARD  = 12'd1700;
    localparam logic [PULSE_W-1:0] RST_PULSE_BACKWARD = 12'd1300;

    typedef struct packed {
        logic               action;
        logic [POS_W-1:0]   target_position;
        logic [TIME_W-1:0]  now_ms;
    } cmd_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic               attached;
        logic               moving;
        logic               direction_forward;
        logic [POS_W-1:0]   position;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0]   min_position;
        logic [POS_W-1:0]   max_position;
        logic [SPEED_W-1:0] speed_per_ms;
        logic [POS_W-1:0]   deadband;
        logic [PULSE_W-1:0] pulse_stop;
        logic [PULSE_W-1:0] pulse_forward;
        logic [PULSE_W-1:0] pulse_backward;
    } cfg_t;

    // Limit to max first, then raise to min: min wins when the limits cross.
    function automatic logic [POS_W-1:0] clamp_pos(
        input logic [POS_W-1:0] v,
        input logic [POS_W-1:0] lo,
        input logic [POS_W-1:0] hi
    );
        logic [POS_W-1:0] r;
        r = (v > hi) ? hi : v;
        r = (r < lo) ? lo : r;
        return r;
    endfunction

endpackage

@@ rtl/drsp_regs.sv @@
// ----------------------------------------------------------------------------
// Servo positioner register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module drsp_regs
    import drsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_MIN_POSITION:   cfg_next.min_position   = pwdata[POS_W-1:0];
                REG_MAX_POSITION:   cfg_next.max_position   = pwdata[POS_W-1:0];
                REG_SPEED_PER_MS:   cfg_next.speed_per_ms   = pwdata[SPEED_W-1:0];
                REG_DEADBAND:       cfg_next.deadband       = pwdata[POS_W-1:0];
                REG_PULSE_STOP:     cfg_next.pulse_stop     = pwdata[PULSE_W-1:0];
                REG_PULSE_FORWARD:  cfg_next.pulse_forward  = pwdata[PULSE_W-1:0];
                REG_PULSE_BACKWARD: cfg_next.pulse_backward = pwdata[PULSE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MIN_POSITION:   prdata = DATA_W'(cfg_reg.min_position);
            REG_MAX_POSITION:   prdata = DATA_W'(cfg_reg.max_position);
            REG_SPEED_PER_MS:   prdata = DATA_W'(cfg_reg.speed_per_ms);
            REG_DEADBAND:       prdata = DATA_W'(cfg_reg.deadband);
            REG_PULSE_STOP:     prdata = DATA_W'(cfg_reg.pulse_stop);
            REG_PULSE_FORWARD:  prdata = DATA_W'(cfg_reg.pulse_forward);
            REG_PULSE_BACKWARD: prdata = DATA_W'(cfg_reg.pulse_backward);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_position   <= RST_MIN_POSITION;
            cfg_reg.max_position   <= RST_MAX_POSITION;
            cfg_reg.speed_per_ms   <= RST_SPEED_PER_MS;
            cfg_reg.deadband       <= RST_DEADBAND;
            cfg_reg.pulse_stop     <= RST_PULSE_STOP;
            cfg_reg.pulse_forward  <= RST_PULSE_FORWARD;
            cfg_reg.pulse_backward <= RST_PULSE_BACKWARD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/drsp_core.sv @@
// ----------------------------------------------------------------------------
// Servo positioner core
// Positioner state and the single-pass move / tick update.
// ----------------------------------------------------------------------------
`include "dead_reckoning_servo_positioner_macros.svh"

module drsp_core
    import drsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    step_en,
    input  cmd_t    cmd,
    output result_t step_result
);

    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [POS_W-1:0]   target_reg,  target_next;
    logic               motion_reg,  motion_next;
    logic               fwd_reg,     fwd_next;
    logic [TIME_W-1:0]  last_ms_reg, last_ms_next;
    logic [PULSE_W-1:0] pulse_reg,   pulse_next;
    logic               enabled_reg, enabled_next;

    // Move command terms
    logic [POS_W-1:0]   mv_target;
    logic               mv_fwd;
    logic [POS_W-1:0]   mv_remain;
    logic               mv_go;

    // Tick terms
    logic [TIME_W-1:0]  elapsed;
    logic [PROD_W-1:0]  product;
    logic [STEP_W-1:0]  step;
    logic [SUM_W-1:0]   fwd_sum;
    logic signed [SUM_W-1:0] bwd_diff;
    logic               reached;
    logic [POS_W-1:0]   tk_raw;
    logic [POS_W-1:0]   tk_pos;

    assign mv_target = clamp_pos(cmd.target_position, cfg.min_position, cfg.max_position);
    assign mv_fwd    = mv_target > pos_reg;
    assign mv_remain = mv_fwd ? (mv_target - pos_reg) : (pos_reg - mv_target);
    assign mv_go     = mv_remain > cfg.deadband;

    // A clock that stood still or wrapped counts as one millisecond
    assign elapsed = (cmd.now_ms > last_ms_reg) ? (cmd.now_ms - last_ms_reg) : TIME_W'(1);
    assign product = PROD_W'(cfg.speed_per_ms) * PROD_W'(elapsed);
    assign step    = (product > STEP_LIMIT) ? STEP_LIMIT[STEP_W-1:0] : product[STEP_W-1:0];

    assign fwd_sum  = SUM_W'(pos_reg) + SUM_W'(step);
    assign bwd_diff = $signed(SUM_W'(pos_reg)) - $signed(SUM_W'(step));
    assign reached  = fwd_reg ? (fwd_sum >= SUM_W'(target_reg))
                              : (bwd_diff <= $signed(SUM_W'(target_reg)));
    // Not reached means the sum stayed below the target (or the difference above it), so it fits the position width
    assign tk_raw   = reached ? target_reg
                              : (fwd_reg ? fwd_sum[POS_W-1:0] : bwd_diff[POS_W-1:0]);
    assign tk_pos   = clamp_pos(tk_raw, cfg.min_position, cfg.max_position);

    always_comb
    begin
        pos_next     = pos_reg;
        target_next  = target_reg;
        motion_next  = motion_reg;
        fwd_next     = fwd_reg;
        last_ms_next = last_ms_reg;
        pulse_next   = pulse_reg;
        enabled_next = enabled_reg;
        if (cmd.action == ACT_MOVE)
        begin
            target_next  = mv_target;
            fwd_next     = mv_fwd;
            enabled_next = mv_go;
            motion_next  = mv_go;
            if (mv_go)
            begin
                last_ms_next = cmd.now_ms;
                pulse_next   = mv_fwd ? cfg.pulse_forward : cfg.pulse_backward;
            end
            else
            begin
                pulse_next = cfg.pulse_stop;
            end
        end
        else if (motion_reg)
        begin
            pos_next     = tk_pos;
            last_ms_next = cmd.now_ms;
            if (reached)
            begin
                motion_next  = 1'b0;
                enabled_next = 1'b0;
                pulse_next   = cfg.pulse_stop;
            end
        end
    end

    always_comb
    begin
        step_result.pulse_width       = pulse_next;
        step_result.attached          = enabled_next;
        step_result.moving            = motion_next;
        step_result.direction_forward = fwd_next;
        step_result.position          = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            target_reg  <= '0;
            motion_reg  <= 1'b0;
            fwd_reg     <= 1'b1;
            last_ms_reg <= '0;
            pulse_reg   <= RST_PULSE_STOP;
            enabled_reg <= 1'b0;
        end
        else if (step_en)
        begin
            pos_reg     <= pos_next;
            target_reg  <= target_next;
            motion_reg  <= motion_next;
            fwd_reg     <= fwd_next;
            last_ms_reg <= last_ms_next;
            pulse_reg   <= pulse_next;
            enabled_reg <= enabled_next;
        end
    end

    `DRSP_ASSERT_IMP(a_motion_drives, motion_reg, enabled_reg,
        "motion active while the drive is detached")
    `DRSP_ASSERT_NXT(a_idle_tick_holds, step_en && cmd.action == ACT_TICK && !motion_reg,
        $stable(pos_reg) && $stable(last_ms_reg) && !motion_reg,
        "tick while idle changed the state")
    `DRSP_ASSERT_NXT(a_hold_without_step, !step_en,
        $stable(pos_reg) && $stable(pulse_reg) && $stable(target_reg),
        "state changed without an accepted word")

endmodule

@@ rtl/dead_reckoning_servo_positioner.sv @@
// ----------------------------------------------------------------------------
// Dead-reckoning servo positioner
// Steers a continuous-rotation servo towards a linear target by integrating
// a configured speed over elapsed milliseconds.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel    : one word per move command (action = 0) or time tick
//                    (action = 1), valid/ready handshake.
//   result channel : exactly one word per accepted cmd word, in order,
//                    carrying pulse width, attach/moving/direction flags and
//                    the position estimate after that word.
//   APB port       : seven configuration registers at byte address 4*index;
//                    write them only while no word is in flight.
//   Path           : an accepted cmd word passes through the input register,
//                    then the result register, to become its result word.
//   Throughput     : one word per cycle while result_ready is high; each update
//                    is a single pass of a 16x32 multiply, an add/compare and the limit clamps.
//   Stall          : while result_ready is low the result register holds,
//                    the input register fills, then cmd_ready drops; no word
//                    is lost or repeated.
//   Reset          : rst_n clears both stages, restores register defaults,
//                    zeroes the position and selects the stop pulse, detached.
// ----------------------------------------------------------------------------
`include "dead_reckoning_servo_positioner_macros.svh"

module dead_reckoning_servo_positioner
    import drsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Command channel
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    // Result channel
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    cfg_t    cfg;
    logic    s1_valid_reg, s1_valid_next;
    cmd_t    s1_reg;
    logic    res_valid_reg, res_valid_next;
    result_t res_reg;
    result_t step_result;
    logic    advance;
    logic    step_en;
    logic    cmd_take;

    drsp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drsp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step_en     (step_en),
        .cmd         (s1_reg),
        .step_result (step_result)
    );

    // Advance the result stage whenever it is empty or being drained
    assign advance   = !res_valid_reg || result_ready;
    // Apply the held word to the state as it moves into the result register
    assign step_en   = s1_valid_reg && advance;
    assign cmd_ready = !s1_valid_reg || advance;
    assign cmd_take  = cmd_valid && cmd_ready;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (cmd_take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: load only, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_reg <= cmd;
        end
        if (step_en)
        begin
            res_reg <= step_result;
        end
    end

    `DRSP_ASSERT_NXT(a_stall_holds_result, res_valid_reg && !result_ready,
        res_valid_reg && $stable(res_reg), "result word changed while stalled")
    `DRSP_ASSERT_NXT(a_held_cmd_stays, s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_reg), "held command word lost under stall")
    `DRSP_ASSERT_IMP(a_ready_when_empty, !s1_valid_reg || !res_valid_reg, cmd_ready,
        "cmd_ready low with room in the pipeline")

endmodule
